// ----- rtl/fcp_pkg.sv -----
`default_nettype none

package fcp_pkg;

  localparam int VEC_W           = 32;
  localparam int MU_W            = 16;
  localparam int COH_W           = 31;
  localparam int NS_W            = VEC_W + 1;
  localparam int SQ_W            = 2 * VEC_W;
  localparam int ROOT_W          = VEC_W;
  localparam int DEN_W           = 33;
  localparam int NUM_W           = 62;
  localparam int QUO_W           = 34;
  localparam int DIV_LANES       = 4;
  localparam int FRAC_SH         = 14;
  localparam int DIR_SH          = 28;
  localparam int SUM_W           = 41;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [DEN_W-1:0] ONE_Q28 = DEN_W'(1) << DIR_SH;

  // divider lanes
  localparam int LANE_G1 = 0;
  localparam int LANE_G2 = 1;
  localparam int LANE_DX = 2;
  localparam int LANE_DY = 3;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7fffffff);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(32'sh80000000);

  typedef struct packed {
    logic signed [VEC_W-1:0] s_tangent_x;
    logic signed [VEC_W-1:0] s_tangent_y;
    logic signed [VEC_W-1:0] s_normal;
    logic [MU_W-1:0]         friction;
    logic [COH_W-1:0]        cohesion;
  } fcp_in_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] r_tangent_x;
    logic signed [VEC_W-1:0] r_tangent_y;
    logic signed [VEC_W-1:0] r_normal;
  } fcp_out_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] tx;
    logic signed [VEC_W-1:0] ty;
    logic signed [VEC_W-1:0] nn;
    logic [MU_W-1:0]         mu;
    logic signed [NS_W-1:0]  ns;
    logic [VEC_W-1:0]        ax;
    logic [VEC_W-1:0]        ay;
    logic                    tzero;
  } fcp_work_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] tx;
    logic signed [VEC_W-1:0] ty;
    logic signed [VEC_W-1:0] nn;
    logic [MU_W-1:0]         mu;
    logic                    tzero;
  } fcp_tail_t;

  typedef logic [NUM_W-1:0] fcp_num_t;
  typedef logic [DEN_W-1:0] fcp_den_t;
  typedef logic [QUO_W-1:0] fcp_quo_t;

  function automatic logic [VEC_W-1:0] sat_vec(input logic signed [SUM_W-1:0] v);
    logic [VEC_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[VEC_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[VEC_W-1:0];
    end else begin
      r = v[VEC_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fcp_front.sv -----
`default_nettype none

module fcp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fcp_pkg::fcp_in_t    in_data,
  output logic                push_valid,
  input  logic                push_full,
  output fcp_pkg::fcp_work_t  push_data
);
  import fcp_pkg::*;

  logic      fr_valid_r, fr_valid_nxt;
  fcp_work_t fr_data_r, fr_data_nxt;
  logic      load;

  // hold the word while the queue is full
  assign in_stall = fr_valid_r && push_full;
  assign load     = !in_stall;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    fr_data_nxt  = fr_data_r;
    if (load) begin
      fr_valid_nxt      = in_valid;
      fr_data_nxt.tx    = in_data.s_tangent_x;
      fr_data_nxt.ty    = in_data.s_tangent_y;
      fr_data_nxt.nn    = in_data.s_normal;
      fr_data_nxt.mu    = in_data.friction;
      fr_data_nxt.ns    = NS_W'(in_data.s_normal) + NS_W'({1'b0, in_data.cohesion});
      fr_data_nxt.ax    = in_data.s_tangent_x[VEC_W-1] ?
                          (~$unsigned(in_data.s_tangent_x) + 1'b1) :
                          $unsigned(in_data.s_tangent_x);
      fr_data_nxt.ay    = in_data.s_tangent_y[VEC_W-1] ?
                          (~$unsigned(in_data.s_tangent_y) + 1'b1) :
                          $unsigned(in_data.s_tangent_y);
      fr_data_nxt.tzero = (in_data.s_tangent_x == '0) && (in_data.s_tangent_y == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_data_r <= fr_data_nxt;
  end

  assign push_valid = fr_valid_r;
  assign push_data  = fr_data_r;

endmodule

`default_nettype wire

// ----- rtl/fcp_queue.sv -----
`default_nettype none

module fcp_queue #(
  parameter int DEPTH = fcp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                full,
  input  fcp_pkg::fcp_work_t  push_data,
  input  logic                pop_req,
  output logic                empty,
  output fcp_pkg::fcp_work_t  pop_data
);
  import fcp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fcp_work_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = count_r == CNT_W'(DEPTH);
  assign empty = count_r == '0;
  assign push  = push_valid && !full;
  assign pop   = pop_req && !empty;

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem[rd_ptr_r];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- rtl/fcp_sqrt.sv -----
`default_nettype none

module fcp_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [fcp_pkg::SQ_W-1:0]   rad_in,
  input  fcp_pkg::fcp_work_t         side_in,
  output logic                       out_valid,
  output logic [fcp_pkg::ROOT_W-1:0] root_out,
  output fcp_pkg::fcp_work_t         side_out
);
  import fcp_pkg::*;

  localparam int STEPS = ROOT_W;
  localparam int REM_W = ROOT_W + 1;
  localparam int CUR_W = REM_W + 2;

  logic              v_r    [STEPS];
  logic [REM_W-1:0]  rem_r  [STEPS];
  logic [ROOT_W-1:0] q_r    [STEPS];
  logic [SQ_W-1:0]   rad_r  [STEPS];
  fcp_work_t         side_r [STEPS];

  // one root bit per stage, two radicand bits brought down each time
  for (genvar g = 0; g < STEPS; g++) begin : g_step
    logic              v_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] q_i;
    logic [SQ_W-1:0]   rad_i;
    fcp_work_t         side_i;
    logic [CUR_W-1:0]  cur, trial;
    logic              fit;

    if (g == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign q_i    = '0;
      assign rad_i  = rad_in;
      assign side_i = side_in;
    end else begin : g_next
      assign v_i    = v_r[g-1];
      assign rem_i  = rem_r[g-1];
      assign q_i    = q_r[g-1];
      assign rad_i  = rad_r[g-1];
      assign side_i = side_r[g-1];
    end

    assign cur   = {rem_i, rad_i[SQ_W-1 -: 2]};
    assign trial = CUR_W'({q_i, 2'b01});
    assign fit   = cur >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_i;
      end
      if (en) begin
        rem_r[g]  <= fit ? REM_W'(cur - trial) : REM_W'(cur);
        q_r[g]    <= {q_i[ROOT_W-2:0], fit};
        rad_r[g]  <= {rad_i[SQ_W-3:0], 2'b00};
        side_r[g] <= side_i;
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign root_out  = q_r[STEPS-1];
  assign side_out  = side_r[STEPS-1];

endmodule

`default_nettype wire

// ----- rtl/fcp_div.sv -----
`default_nettype none

module fcp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  fcp_pkg::fcp_num_t  num_in [fcp_pkg::DIV_LANES],
  input  fcp_pkg::fcp_den_t  den_in [fcp_pkg::DIV_LANES],
  input  fcp_pkg::fcp_tail_t side_in,
  output logic               out_valid,
  output fcp_pkg::fcp_quo_t  quo_out [fcp_pkg::DIV_LANES],
  output fcp_pkg::fcp_tail_t side_out
);
  import fcp_pkg::*;

  localparam int STEPS = QUO_W;

  logic      v_r    [STEPS];
  fcp_tail_t side_r [STEPS];
  fcp_den_t  rem_r  [STEPS][DIV_LANES];
  fcp_quo_t  low_r  [STEPS][DIV_LANES];
  fcp_den_t  den_r  [STEPS][DIV_LANES];

  // restoring division, one quotient bit per stage; the numerator's upper
  // part starts out as the remainder since every quotient fits QUO_W bits
  for (genvar g = 0; g < STEPS; g++) begin : g_step
    logic      v_i;
    fcp_tail_t side_i;

    if (g == 0) begin : g_first
      assign v_i    = in_valid;
      assign side_i = side_in;
    end else begin : g_next
      assign v_i    = v_r[g-1];
      assign side_i = side_r[g-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_i;
      end
      if (en) begin
        side_r[g] <= side_i;
      end
    end

    for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
      fcp_den_t         rem_i, den_i;
      fcp_quo_t         low_i;
      logic [DEN_W:0]   cur;
      logic             fit;

      if (g == 0) begin : g_first
        assign rem_i = DEN_W'(num_in[l][NUM_W-1:QUO_W]);
        assign low_i = num_in[l][QUO_W-1:0];
        assign den_i = den_in[l];
      end else begin : g_next
        assign rem_i = rem_r[g-1][l];
        assign low_i = low_r[g-1][l];
        assign den_i = den_r[g-1][l];
      end

      assign cur = {rem_i, low_i[QUO_W-1]};
      assign fit = cur >= {1'b0, den_i};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g][l] <= fit ? DEN_W'(cur - {1'b0, den_i}) : DEN_W'(cur);
          low_r[g][l] <= {low_i[QUO_W-2:0], fit};
          den_r[g][l] <= den_i;
        end
      end
    end
  end

  for (genvar l = 0; l < DIV_LANES; l++) begin : g_out
    assign quo_out[l] = low_r[STEPS-1][l];
  end

  assign out_valid = v_r[STEPS-1];
  assign side_out  = side_r[STEPS-1];

endmodule

`default_nettype wire

// ----- rtl/fcp_back.sv -----
`default_nettype none

module fcp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  output logic                pop_req,
  input  fcp_pkg::fcp_work_t  pop_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fcp_pkg::fcp_out_t   out_data
);
  import fcp_pkg::*;

  localparam int MUS_W   = MU_W + ROOT_W;
  localparam int MUNS_W  = MU_W + 1 + NS_W;
  localparam int RAW_W   = MUNS_W + 1;
  localparam int CLAMP_W = NUM_W - FRAC_SH;
  localparam int G1_W    = 32;
  localparam int G2_W    = QUO_W;
  localparam int DIR_W   = DIR_SH + 1;
  localparam int MUG1_W  = MU_W + G1_W;
  localparam int MUG2_W  = MU_W + G2_W;
  localparam int TRAW_W  = MUG2_W;
  localparam int NRAW_W  = MUG2_W + 1;
  localparam int SMAG_W  = TRAW_W - FRAC_SH;
  localparam int NEXC_W  = NRAW_W + 1 - FRAC_SH;
  localparam int PROD_W  = SMAG_W + DIR_W;
  localparam int MXM_W   = PROD_W + 1 - DIR_SH;

  localparam logic [TRAW_W-1:0] HALF_T = TRAW_W'(1) << (FRAC_SH - 1);
  localparam logic [NRAW_W:0]   HALF_N = (NRAW_W + 1)'(1) << (FRAC_SH - 1);
  localparam logic [PROD_W:0]   HALF_P = (PROD_W + 1)'(1) << (DIR_SH - 1);

  logic en;
  logic out_valid_r;
  fcp_out_t out_data_r;

  // the whole back pipe advances unless the output word is held
  assign en      = !out_valid_r || !out_stall;
  assign pop_req = en;

  // squares of the tangential magnitudes
  logic            p1_v_r;
  fcp_work_t       p1_w_r;
  logic [SQ_W-1:0] p1_sqx_r, p1_sqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= !q_empty;
    end
    if (en) begin
      p1_w_r   <= pop_data;
      p1_sqx_r <= pop_data.ax * pop_data.ax;
      p1_sqy_r <= pop_data.ay * pop_data.ay;
    end
  end

  logic            p2_v_r;
  fcp_work_t       p2_w_r;
  logic [SQ_W-1:0] p2_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (en) begin
      p2_v_r <= p1_v_r;
    end
    if (en) begin
      p2_w_r   <= p1_w_r;
      p2_sum_r <= p1_sqx_r + p1_sqy_r;
    end
  end

  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  fcp_work_t         sq_w;

  fcp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (p2_v_r),
    .rad_in   (p2_sum_r),
    .side_in  (p2_w_r),
    .out_valid(sq_v),
    .root_out (sq_root),
    .side_out (sq_w)
  );

  // products for the spectral numerators and 1 + mu^2
  logic                     q1_v_r;
  fcp_work_t                q1_w_r;
  logic [ROOT_W-1:0]        q1_s_r;
  logic [MUS_W-1:0]         q1_mus_r;
  logic signed [MUNS_W-1:0] q1_muns_r;
  fcp_den_t                 q1_den_r;
  logic [2*MU_W-1:0]        mumu;

  assign mumu = sq_w.mu * sq_w.mu;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_v_r <= 1'b0;
    end else if (en) begin
      q1_v_r <= sq_v;
    end
    if (en) begin
      q1_w_r    <= sq_w;
      q1_s_r    <= sq_root;
      q1_mus_r  <= sq_w.mu * sq_root;
      q1_muns_r <= $signed({1'b0, sq_w.mu}) * sq_w.ns;
      q1_den_r  <= ONE_Q28 + DEN_W'(mumu);
    end
  end

  logic signed [RAW_W-1:0] a_raw, b_raw;
  logic [CLAMP_W-1:0]      a_cl, b_cl;

  assign a_raw = -(RAW_W'(q1_w_r.ns) <<< FRAC_SH) - $signed(RAW_W'(q1_mus_r));
  assign b_raw = ($signed(RAW_W'(q1_s_r)) <<< FRAC_SH) - RAW_W'(q1_muns_r);
  // clamp both spectral values at zero
  assign a_cl  = a_raw[RAW_W-1] ? '0 : a_raw[CLAMP_W-1:0];
  assign b_cl  = b_raw[RAW_W-1] ? '0 : b_raw[CLAMP_W-1:0];

  logic      q2_v_r;
  fcp_tail_t q2_t_r;
  fcp_num_t  q2_num_r [DIV_LANES];
  fcp_den_t  q2_den_r [DIV_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q2_v_r <= 1'b0;
    end else if (en) begin
      q2_v_r <= q1_v_r;
    end
    if (en) begin
      q2_t_r.tx    <= q1_w_r.tx;
      q2_t_r.ty    <= q1_w_r.ty;
      q2_t_r.nn    <= q1_w_r.nn;
      q2_t_r.mu    <= q1_w_r.mu;
      q2_t_r.tzero <= q1_w_r.tzero;
      q2_num_r[LANE_G1] <= {a_cl, {FRAC_SH{1'b0}}};
      q2_num_r[LANE_G2] <= {b_cl, {FRAC_SH{1'b0}}};
      q2_num_r[LANE_DX] <= NUM_W'({q1_w_r.ax, {DIR_SH{1'b0}}});
      q2_num_r[LANE_DY] <= NUM_W'({q1_w_r.ay, {DIR_SH{1'b0}}});
      q2_den_r[LANE_G1] <= q1_den_r;
      q2_den_r[LANE_G2] <= q1_den_r;
      q2_den_r[LANE_DX] <= DEN_W'(q1_s_r);
      q2_den_r[LANE_DY] <= DEN_W'(q1_s_r);
    end
  end

  logic      dv_v;
  fcp_quo_t  dv_quo [DIV_LANES];
  fcp_tail_t dv_t;

  fcp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (q2_v_r),
    .num_in   (q2_num_r),
    .den_in   (q2_den_r),
    .side_in  (q2_t_r),
    .out_valid(dv_v),
    .quo_out  (dv_quo),
    .side_out (dv_t)
  );

  // mu times the clamped values; default direction when tangent is zero
  logic              r1_v_r;
  fcp_tail_t         r1_t_r;
  logic [G1_W-1:0]   r1_g1_r;
  logic [G2_W-1:0]   r1_g2_r;
  logic [DIR_W-1:0]  r1_dxm_r, r1_dym_r;
  logic [MUG1_W-1:0] r1_mug1_r;
  logic [MUG2_W-1:0] r1_mug2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r <= 1'b0;
    end else if (en) begin
      r1_v_r <= dv_v;
    end
    if (en) begin
      r1_t_r    <= dv_t;
      r1_g1_r   <= dv_quo[LANE_G1][G1_W-1:0];
      r1_g2_r   <= dv_quo[LANE_G2];
      r1_dxm_r  <= dv_t.tzero ? ONE_Q28[DIR_W-1:0] : dv_quo[LANE_DX][DIR_W-1:0];
      r1_dym_r  <= dv_t.tzero ? '0 : dv_quo[LANE_DY][DIR_W-1:0];
      r1_mug1_r <= dv_t.mu * dv_quo[LANE_G1][G1_W-1:0];
      r1_mug2_r <= dv_t.mu * dv_quo[LANE_G2];
    end
  end

  logic                     r2_v_r;
  fcp_tail_t                r2_t_r;
  logic [DIR_W-1:0]         r2_dxm_r, r2_dym_r;
  logic signed [TRAW_W-1:0] r2_traw_r;
  logic [NRAW_W-1:0]        r2_nraw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r2_v_r <= 1'b0;
    end else if (en) begin
      r2_v_r <= r1_v_r;
    end
    if (en) begin
      r2_t_r    <= r1_t_r;
      r2_dxm_r  <= r1_dxm_r;
      r2_dym_r  <= r1_dym_r;
      r2_traw_r <= (TRAW_W'(r1_g2_r) << FRAC_SH) - TRAW_W'(r1_mug1_r);
      r2_nraw_r <= (NRAW_W'(r1_g1_r) << FRAC_SH) + NRAW_W'(r1_mug2_r);
    end
  end

  // round both excess terms to Q16.16, ties away from zero
  logic [TRAW_W-1:0] tmag, tsum;
  logic [NRAW_W:0]   nsum;

  assign tmag = r2_traw_r[TRAW_W-1] ? (~$unsigned(r2_traw_r) + 1'b1) : $unsigned(r2_traw_r);
  assign tsum = tmag + HALF_T;
  assign nsum = (NRAW_W + 1)'(r2_nraw_r) + HALF_N;

  logic              r3_v_r;
  fcp_tail_t         r3_t_r;
  logic [DIR_W-1:0]  r3_dxm_r, r3_dym_r;
  logic [SMAG_W-1:0] r3_smag_r;
  logic              r3_sneg_r;
  logic [NEXC_W-1:0] r3_nexc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r3_v_r <= 1'b0;
    end else if (en) begin
      r3_v_r <= r2_v_r;
    end
    if (en) begin
      r3_t_r    <= r2_t_r;
      r3_dxm_r  <= r2_dxm_r;
      r3_dym_r  <= r2_dym_r;
      r3_smag_r <= tsum[TRAW_W-1:FRAC_SH];
      r3_sneg_r <= r2_traw_r[TRAW_W-1];
      r3_nexc_r <= nsum[NRAW_W:FRAC_SH];
    end
  end

  logic                    r4_v_r;
  logic signed [VEC_W-1:0] r4_tx_r, r4_ty_r, r4_nn_r;
  logic [NEXC_W-1:0]       r4_nexc_r;
  logic [PROD_W-1:0]       r4_px_r, r4_py_r;
  logic                    r4_xneg_r, r4_yneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r4_v_r <= 1'b0;
    end else if (en) begin
      r4_v_r <= r3_v_r;
    end
    if (en) begin
      r4_tx_r   <= r3_t_r.tx;
      r4_ty_r   <= r3_t_r.ty;
      r4_nn_r   <= r3_t_r.nn;
      r4_nexc_r <= r3_nexc_r;
      r4_px_r   <= r3_smag_r * r3_dxm_r;
      r4_py_r   <= r3_smag_r * r3_dym_r;
      r4_xneg_r <= r3_sneg_r ^ r3_t_r.tx[VEC_W-1];
      r4_yneg_r <= r3_sneg_r ^ r3_t_r.ty[VEC_W-1];
    end
  end

  logic [PROD_W:0]         pxs, pys;
  logic [MXM_W-1:0]        mxm, mym;
  logic signed [SUM_W-1:0] mx, my;

  assign pxs = (PROD_W + 1)'(r4_px_r) + HALF_P;
  assign pys = (PROD_W + 1)'(r4_py_r) + HALF_P;
  assign mxm = pxs[PROD_W:DIR_SH];
  assign mym = pys[PROD_W:DIR_SH];
  assign mx  = r4_xneg_r ? -$signed(SUM_W'(mxm)) : $signed(SUM_W'(mxm));
  assign my  = r4_yneg_r ? -$signed(SUM_W'(mym)) : $signed(SUM_W'(mym));

  logic                    r5_v_r;
  logic signed [VEC_W-1:0] r5_tx_r, r5_ty_r, r5_nn_r;
  logic [NEXC_W-1:0]       r5_nexc_r;
  logic signed [SUM_W-1:0] r5_mx_r, r5_my_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r5_v_r <= 1'b0;
    end else if (en) begin
      r5_v_r <= r4_v_r;
    end
    if (en) begin
      r5_tx_r   <= r4_tx_r;
      r5_ty_r   <= r4_ty_r;
      r5_nn_r   <= r4_nn_r;
      r5_nexc_r <= r4_nexc_r;
      r5_mx_r   <= mx;
      r5_my_r   <= my;
    end
  end

  logic signed [SUM_W-1:0] rx, ry, rn;

  assign rx = SUM_W'(r5_tx_r) - r5_mx_r;
  assign ry = SUM_W'(r5_ty_r) - r5_my_r;
  assign rn = SUM_W'(r5_nn_r) + $signed(SUM_W'(r5_nexc_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= r5_v_r;
    end
    if (en) begin
      out_data_r.r_tangent_x <= sat_vec(rx);
      out_data_r.r_tangent_y <= sat_vec(ry);
      out_data_r.r_normal    <= sat_vec(rn);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_dir_unit: assert property (@(posedge clk) disable iff (!rst_n)
    r1_v_r |-> (r1_dxm_r <= ONE_Q28[DIR_W-1:0]) && (r1_dym_r <= ONE_Q28[DIR_W-1:0]))
    else $error("direction component above one");

  a_g1_headroom: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v |-> (dv_quo[LANE_G1][QUO_W-1:G1_W] == '0))
    else $error("first spectral quotient overflows its field");

endmodule

`default_nettype wire

// ----- rtl/friction_cone_projection_unit.sv -----
// Channel   Handshake            Word         Direction
// in        in_valid / in_stall  in_data      contact vector, friction, cohesion
// out       out_valid/out_stall  out_data     projected vector, saturated
//
// One word per cycle sustained while out_stall does not freeze the back pipe.
// Most of the latency lies in the 32-stage square root and the 34-stage divider bank.
// Reset (rst_n low, synchronous) empties the queue and clears every valid bit.
// out_stall with out_valid high freezes the back pipe; the front keeps filling the queue and
// raises in_stall once the queue is full.
`default_nettype none

module friction_cone_projection_unit #(
  parameter int QUEUE_DEPTH = fcp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fcp_pkg::fcp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fcp_pkg::fcp_out_t out_data
);
  import fcp_pkg::*;

  logic      push_valid, q_full, q_empty, pop_req;
  fcp_work_t push_data, pop_data;

  fcp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push_valid(push_valid),
    .push_full (q_full),
    .push_data (push_data)
  );

  fcp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .full      (q_full),
    .push_data (push_data),
    .pop_req   (pop_req),
    .empty     (q_empty),
    .pop_data  (pop_data)
  );

  fcp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .pop_req  (pop_req),
    .pop_data (pop_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import fcp_pkg::*;

  localparam int LATENCY = 78;
  localparam int N_RANDOM = 1000;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fcp_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fcp_out_t out_data;

  fcp_out_t projected_q[$];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 1'b0;
  bit stim_done = 1'b0;

  friction_cone_projection_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint rnd_shift(input longint v, input int sh);
    longint m;
    m = (mag(v) + (64'sd1 <<< (sh - 1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint dir_excess(input longint sc, input longint dir);
    logic [63:0] p;
    p = (64'(mag(sc)) * 64'(mag(dir)) + (64'd1 << 27)) >> 28;
    return ((sc < 0) != (dir < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic fcp_out_t project_cone(input fcp_in_t w);
    longint tx, ty, nn, mu, ns, ax, ay, s, d, a, b, g1, g2, dx, dy, sc, nexc;
    logic [63:0] sq;
    fcp_out_t r;
    tx = longint'(w.s_tangent_x);
    ty = longint'(w.s_tangent_y);
    nn = longint'(w.s_normal);
    mu = longint'({1'b0, w.friction});
    ns = nn + longint'({1'b0, w.cohesion});
    ax = mag(tx);
    ay = mag(ty);
    sq = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
    s = int_sqrt(sq);
    d = (64'sd1 <<< 28) + mu * mu;
    a = -(ns * 16384) - mu * s;
    b = s * 16384 - mu * ns;
    if (a < 0) a = 0;
    if (b < 0) b = 0;
    g1 = longint'((64'(a) << 14) / 64'(d));
    g2 = longint'((64'(b) << 14) / 64'(d));
    if (s != 0) begin
      dx = longint'((64'(ax) << 28) / 64'(s));
      dy = longint'((64'(ay) << 28) / 64'(s));
      if (tx < 0) dx = -dx;
      if (ty < 0) dy = -dy;
    end else begin
      // zero tangent: default direction (1,0)
      dx = 64'sd1 <<< 28;
      dy = 0;
    end
    sc = rnd_shift(g2 * 16384 - mu * g1, 14);
    nexc = rnd_shift(g1 * 16384 + mu * g2, 14);
    r.r_tangent_x = clamp32(tx - dir_excess(sc, dx));
    r.r_tangent_y = clamp32(ty - dir_excess(sc, dy));
    r.r_normal = clamp32(nn + nexc);
    return r;
  endfunction

  function automatic logic [31:0] rand_vec();
    case ($urandom_range(0, 5))
      0: return 32'($signed($urandom_range(0, 2000)) - 1000);
      1: return 32'($signed($urandom_range(0, 32'h00200000)) - 32'sh00100000);
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic fcp_in_t rand_word();
    fcp_in_t w;
    w.s_tangent_x = rand_vec();
    w.s_tangent_y = $urandom_range(0, 7) == 0 ? 32'h0 : rand_vec();
    w.s_normal = rand_vec();
    w.friction = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 20000));
    case ($urandom_range(0, 3))
      0: w.cohesion = '0;
      1: w.cohesion = 31'($urandom_range(0, 32'h00080000));
      default: w.cohesion = 31'($urandom);
    endcase
    return w;
  endfunction

  // directed rows: expectation typed in where obvious, else predicted
  typedef struct {
    fcp_in_t w;
    bit has_exp;
    fcp_out_t exp;
  } row_t;

  row_t rows[$];

  function automatic row_t mk(input logic [31:0] tx, input logic [31:0] ty,
                              input logic [31:0] n, input logic [15:0] mu,
                              input logic [30:0] c, input bit he,
                              input logic [95:0] e);
    row_t r;
    r.w = {tx, ty, n, mu, c};
    r.has_exp = he;
    r.exp = e;
    return r;
  endfunction

  initial begin
    rows.push_back(mk(0, 0, 0, 0, 0, 1, {32'h0, 32'h0, 32'h0}));
    // inside the cone: unchanged
    rows.push_back(mk(32'h00010000, 0, 32'h00100000, 16'h4000, 0, 1,
                      {32'h00010000, 32'h0, 32'h00100000}));
    rows.push_back(mk(0, 0, 32'h80000000, 16'hffff, 0, 0, 0));
    rows.push_back(mk(0, 0, 32'h00010000, 0, 0, 0, 0));
    rows.push_back(mk(0, 0, 32'h7fffffff, 16'hffff, 31'h7fffffff, 0, 0));
    rows.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 31'h7fffffff, 0, 0));
    rows.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000, 16'hffff, 0, 0, 0));
    rows.push_back(mk(32'h80000000, 0, 32'h7fffffff, 16'hffff, 31'h7fffffff, 0, 0));
    rows.push_back(mk(32'h00010000, 32'h00010000, 0, 16'h4000, 0, 0, 0));
    rows.push_back(mk(32'hffff0000, 32'h00020000, 32'h00010000, 16'h2000, 0, 0, 0));
    rows.push_back(mk(0, 32'hffff0000, 32'hffff0000, 16'h4000, 31'h00020000, 0, 0));
    rows.push_back(mk(32'h00000001, 32'hffffffff, 32'h00000001, 16'h0001, 0, 0, 0));
    rows.push_back(mk(32'h7fffffff, 0, 32'h80000000, 0, 0, 0, 0));
    rows.push_back(mk(32'h55555555, 32'haaaaaaaa, 32'h55555555, 16'haaaa, 31'h2aaaaaaa, 0, 0));
    rows.push_back(mk(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 16'h5555, 31'h55555555, 0, 0));
  end

  task automatic send_word(input fcp_in_t w, input bit has_exp, input fcp_out_t e);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    projected_q.push_back(has_exp ? e : project_cone(w));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) send_word(rows[i].w, rows[i].has_exp, rows[i].exp);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 150) quiet = 1'b1;
      send_word(rand_word(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver back-pressure
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (projected_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        errors++;
      end else begin
        fcp_out_t e;
        e = projected_q.pop_front();
        if (e.r_tangent_x !== out_data.r_tangent_x)
          $display("%0t: r_tangent_x expected %h actual %h", $time,
                   e.r_tangent_x, out_data.r_tangent_x);
        if (e.r_tangent_y !== out_data.r_tangent_y)
          $display("%0t: r_tangent_y expected %h actual %h", $time,
                   e.r_tangent_y, out_data.r_tangent_y);
        if (e.r_normal !== out_data.r_normal)
          $display("%0t: r_normal expected %h actual %h", $time,
                   e.r_normal, out_data.r_normal);
        if (e !== out_data) errors++;
      end
    end
  end

  initial begin
    wait (stim_done && projected_q.size() == 0 || cycles >= CYCLE_LIMIT);
    if (cycles < CYCLE_LIMIT) begin
      repeat (2 * LATENCY) @(posedge clk);
      if (errors == 0) $display("tb OK");
      else $display("tb NOT OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
